@@ src/tfp_pkg.sv @@
// shared types and constants of the thermal fan and peltier controller
package tfp_pkg;

  localparam int TempW    = 8;
  localparam int DutyW    = 8;
  localparam int CfgIdxW  = 3;
  localparam int ProdW    = 2 * DutyW;
  localparam int DivSteps = ProdW;
  localparam int StepCntW = $clog2(DivSteps);

  typedef logic signed [TempW-1:0] temp_t;
  typedef logic [DutyW-1:0]        duty_t;
  typedef logic [CfgIdxW-1:0]      cfg_idx_t;

  // register indexes
  localparam cfg_idx_t RegFanLowTemp       = 3'd0;
  localparam cfg_idx_t RegFanHighTemp      = 3'd1;
  localparam cfg_idx_t RegFanMinDuty       = 3'd2;
  localparam cfg_idx_t RegFanMaxDuty       = 3'd3;
  localparam cfg_idx_t RegOverheatTripTemp = 3'd4;
  localparam cfg_idx_t RegOverheatClrTemp  = 3'd5;
  localparam cfg_idx_t RegWaterOnTemp      = 3'd6;
  localparam cfg_idx_t RegWaterOffTemp     = 3'd7;

  // register reset values
  localparam temp_t RstFanLowTemp       = 8'sd30;
  localparam temp_t RstFanHighTemp      = 8'sd70;
  localparam duty_t RstFanMinDuty       = 8'd60;
  localparam duty_t RstFanMaxDuty       = 8'd255;
  localparam temp_t RstOverheatTripTemp = 8'sd70;
  localparam temp_t RstOverheatClrTemp  = 8'sd50;
  localparam temp_t RstWaterOnTemp      = 8'sd20;
  localparam temp_t RstWaterOffTemp     = 8'sd17;

  typedef struct packed {
    logic     en;
    cfg_idx_t idx;
    duty_t    data;
  } cfg_wr_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic step;
    logic finish;
    logic chan_b;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    duty_t fan_duty_a;
    duty_t fan_duty_b;
    logic  peltier_on_a;
    logic  peltier_on_b;
    logic  pump_on;
    logic  overheat_a;
    logic  overheat_b;
  } result_t;

endpackage

@@ src/tfp_sample_if.sv @@
// input channel carrying one temperature sample per beat
interface tfp_sample_if;
  import tfp_pkg::*;

  logic  valid;
  logic  ready;
  temp_t water_temp;
  temp_t radiator_temp_a;
  temp_t radiator_temp_b;

  modport source (output valid, output water_temp, output radiator_temp_a,
                  output radiator_temp_b, input ready);
  modport sink (input valid, input water_temp, input radiator_temp_a,
                input radiator_temp_b, output ready);
endinterface

@@ src/tfp_result_if.sv @@
// output channel carrying fan duties and enables per beat
interface tfp_result_if;
  import tfp_pkg::*;

  logic  valid;
  logic  ready;
  duty_t fan_duty_a;
  duty_t fan_duty_b;
  logic  peltier_on_a;
  logic  peltier_on_b;
  logic  pump_on;
  logic  overheat_a;
  logic  overheat_b;

  modport source (output valid, output fan_duty_a, output fan_duty_b,
                  output peltier_on_a, output peltier_on_b, output pump_on,
                  output overheat_a, output overheat_b, input ready);
  modport sink (input valid, input fan_duty_a, input fan_duty_b,
                input peltier_on_a, input peltier_on_b, input pump_on,
                input overheat_a, input overheat_b, output ready);
endinterface

@@ src/tfp_cfg_if.sv @@
// configuration write channel
interface tfp_cfg_if;
  import tfp_pkg::*;

  logic     valid;
  logic     ready;
  cfg_idx_t index;
  duty_t    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/tfp_ctrl.sv @@
// sequencer: accepts a sample, runs the shared divider for both channels, emits the result
module tfp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            out_ready,
  output logic            out_valid,
  output tfp_pkg::dp_cmd_t cmd
);
  import tfp_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [StepCntW-1:0] LastStep = StepCntW'(DivSteps - 1);

  logic [2:0]          state, state_next;
  logic                chan_b, chan_b_next;
  logic [StepCntW-1:0] step_cnt, step_cnt_next;
  logic                out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    chan_b_next   = chan_b;
    step_cnt_next = step_cnt;
    cmd           = '0;
    cmd.chan_b    = chan_b;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          chan_b_next = 1'b0;
          state_next  = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load      = 1'b1;
        step_cnt_next = '0;
        state_next    = S_DIV;
      end
      S_DIV: begin
        cmd.step      = 1'b1;
        step_cnt_next = step_cnt + 1'b1;
        if (step_cnt == LastStep) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        if (chan_b) begin
          state_next = S_DONE;
        end else begin
          chan_b_next = 1'b1;
          state_next  = S_LOAD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      chan_b    <= 1'b0;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      chan_b   <= chan_b_next;
      step_cnt <= step_cnt_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

@@ src/tfp_dp.sv @@
// datapath: config registers, hysteresis state, fan map with restoring divider, result register
module tfp_dp (
  input  logic              clk,
  input  logic              rst,
  input  tfp_pkg::cfg_wr_t  cfg_wr,
  input  tfp_pkg::temp_t    water_temp,
  input  tfp_pkg::temp_t    radiator_temp_a,
  input  tfp_pkg::temp_t    radiator_temp_b,
  input  tfp_pkg::dp_cmd_t  cmd,
  output tfp_pkg::result_t  res
);
  import tfp_pkg::*;

  temp_t fan_low_temp, fan_high_temp, trip_temp, clr_temp, water_on, water_off;
  duty_t fan_min_duty, fan_max_duty;

  logic  cooling_request, latch_a, latch_b;
  temp_t rad_a, rad_b;

  // per-channel map state
  logic [ProdW-1:0] quo;
  logic [DutyW:0]   rem;
  duty_t            divisor;
  logic             neg;
  logic             use_map;
  duty_t            fixed_duty;
  duty_t            duty_a, duty_b;

  // load-stage selection
  temp_t            rad_sel;
  logic             latch_sel;
  logic [TempW:0]   diff;
  logic [TempW:0]   span;
  logic             dneg;
  duty_t            dmag;
  logic             map_sel;
  duty_t            fixed_sel;

  // divider step
  logic [DutyW:0]   rem_sh;
  logic             fits;

  duty_t            duty_val;

  function automatic logic latch_upd(input logic cur, input temp_t rad,
                                     input temp_t trip, input temp_t clr);
    logic r;
    if (rad > trip) begin
      r = 1'b1;
    end else if (rad <= clr) begin
      r = 1'b0;
    end else begin
      r = cur;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      fan_low_temp  <= RstFanLowTemp;
      fan_high_temp <= RstFanHighTemp;
      fan_min_duty  <= RstFanMinDuty;
      fan_max_duty  <= RstFanMaxDuty;
      trip_temp     <= RstOverheatTripTemp;
      clr_temp      <= RstOverheatClrTemp;
      water_on      <= RstWaterOnTemp;
      water_off     <= RstWaterOffTemp;
    end else if (cfg_wr.en) begin
      case (cfg_wr.idx)
        RegFanLowTemp:       fan_low_temp  <= temp_t'(cfg_wr.data);
        RegFanHighTemp:      fan_high_temp <= temp_t'(cfg_wr.data);
        RegFanMinDuty:       fan_min_duty  <= cfg_wr.data;
        RegFanMaxDuty:       fan_max_duty  <= cfg_wr.data;
        RegOverheatTripTemp: trip_temp     <= temp_t'(cfg_wr.data);
        RegOverheatClrTemp:  clr_temp      <= temp_t'(cfg_wr.data);
        RegWaterOnTemp:      water_on      <= temp_t'(cfg_wr.data);
        RegWaterOffTemp:     water_off     <= temp_t'(cfg_wr.data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cooling_request <= 1'b0;
      latch_a         <= 1'b0;
      latch_b         <= 1'b0;
    end else if (cmd.capture) begin
      if (water_temp >= water_on) begin
        cooling_request <= 1'b1;
      end else if (water_temp <= water_off) begin
        cooling_request <= 1'b0;
      end
      latch_a <= latch_upd(latch_a, radiator_temp_a, trip_temp, clr_temp);
      latch_b <= latch_upd(latch_b, radiator_temp_b, trip_temp, clr_temp);
    end
  end

  always_comb begin
    rad_sel   = cmd.chan_b ? rad_b : rad_a;
    latch_sel = cmd.chan_b ? latch_b : latch_a;
    diff      = {rad_sel[TempW-1], rad_sel} - {fan_low_temp[TempW-1], fan_low_temp};
    span      = {fan_high_temp[TempW-1], fan_high_temp}
              - {fan_low_temp[TempW-1], fan_low_temp};
    dneg      = fan_max_duty < fan_min_duty;
    dmag      = dneg ? (fan_min_duty - fan_max_duty) : (fan_max_duty - fan_min_duty);
    map_sel   = 1'b0;
    fixed_sel = fan_max_duty;
    if (latch_sel) begin
      fixed_sel = fan_max_duty;
    end else if (rad_sel < fan_low_temp) begin
      fixed_sel = '0;
    end else if (rad_sel > fan_high_temp) begin
      fixed_sel = fan_max_duty;
    end else if (fan_high_temp == fan_low_temp) begin
      fixed_sel = fan_min_duty;
    end else begin
      map_sel = 1'b1;
    end
  end

  assign rem_sh = {rem[DutyW-1:0], quo[ProdW-1]};
  assign fits   = rem_sh >= {1'b0, divisor};

  // truncation toward zero: magnitude quotient, sign applied afterwards
  assign duty_val = !use_map ? fixed_duty
                  : neg ? (fan_min_duty - quo[DutyW-1:0])
                  : (fan_min_duty + quo[DutyW-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rad_a <= radiator_temp_a;
      rad_b <= radiator_temp_b;
    end
    if (cmd.load) begin
      quo        <= ProdW'(diff[DutyW-1:0]) * ProdW'(dmag);
      rem        <= '0;
      divisor    <= span[DutyW-1:0];
      neg        <= dneg;
      use_map    <= map_sel;
      fixed_duty <= fixed_sel;
    end else if (cmd.step) begin
      rem <= fits ? (rem_sh - {1'b0, divisor}) : rem_sh;
      quo <= {quo[ProdW-2:0], fits};
    end
    if (cmd.finish) begin
      if (cmd.chan_b) begin
        duty_b <= duty_val;
      end else begin
        duty_a <= duty_val;
      end
    end
    if (cmd.emit) begin
      res.fan_duty_a   <= duty_a;
      res.fan_duty_b   <= duty_b;
      res.peltier_on_a <= cooling_request && !latch_a;
      res.peltier_on_b <= cooling_request && !latch_b;
      res.pump_on      <= cooling_request && !(latch_a && latch_b);
      res.overheat_a   <= latch_a;
      res.overheat_b   <= latch_b;
    end
  end
endmodule

@@ src/thermal_fan_peltier_controller.sv @@
// top level of the two-channel fan and peltier controller
// one sample at a time: both fan maps share one restoring divider, 16 steps per channel
// result is registered once both channels have finished, held in an output register until taken
// a new sample is accepted while an earlier result still waits on the output
// synchronous reset restores the register defaults and clears both overheat latches and the
// cooling request; no clearing pass is needed
module thermal_fan_peltier_controller (
  input  logic         clk,
  input  logic         rst,
  tfp_sample_if.sink   sample,
  tfp_result_if.source result,
  tfp_cfg_if.sink      cfg
);
  import tfp_pkg::*;

  dp_cmd_t cmd;
  cfg_wr_t cfg_wr;
  result_t res;

  assign cfg.ready   = 1'b1;
  assign cfg_wr.en   = cfg.valid;
  assign cfg_wr.idx  = cfg.index;
  assign cfg_wr.data = cfg.data;

  tfp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .cmd       (cmd)
  );

  tfp_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr          (cfg_wr),
    .water_temp      (sample.water_temp),
    .radiator_temp_a (sample.radiator_temp_a),
    .radiator_temp_b (sample.radiator_temp_b),
    .cmd             (cmd),
    .res             (res)
  );

  assign result.fan_duty_a   = res.fan_duty_a;
  assign result.fan_duty_b   = res.fan_duty_b;
  assign result.peltier_on_a = res.peltier_on_a;
  assign result.peltier_on_b = res.peltier_on_b;
  assign result.pump_on      = res.pump_on;
  assign result.overheat_a   = res.overheat_a;
  assign result.overheat_b   = res.overheat_b;
endmodule
